// ===== sv/xor_checked_packet_deframer_core_macros.svh =====
// Assertion helpers for the deframer; expect clk and arst_n in scope.
`ifndef XOR_CHECKED_PACKET_DEFRAMER_CORE_MACROS_SVH
`define XOR_CHECKED_PACKET_DEFRAMER_CORE_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define XCPD_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("xcpd assertion failed");

// Check that cond holds in the cycle after trig.
`define XCPD_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("xcpd assertion failed");

`endif

// ===== sv/xcpd_pkg.sv =====
package xcpd_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	localparam int BYTE_W = 8;
	localparam int CMD_W = 8;
	localparam int PLEN_W = 6;
	localparam int BIDX_W = 5;
	localparam int OUT_BITS = CMD_W + PLEN_W + BIDX_W + BYTE_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_TDATA_W - OUT_BITS;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_CMD   = 3'd1,
		PH_LEN   = 3'd2,
		PH_DATA  = 3'd3,
		PH_CHECK = 3'd4
	} phase_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic             go;
		logic [CMD_W-1:0] cmd;
		logic [LEN_W-1:0] len;
	} start_t;

	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [BYTE_W-1:0]    payload_byte;
		logic [BIDX_W-1:0]    byte_index;
		logic [PLEN_W-1:0]    data_len;
		logic [CMD_W-1:0]     opcode;
	} out_data_t;

endpackage

// ===== sv/xcpd_store_emit.sv =====
module xcpd_store_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  xcpd_pkg::wr_req_t           wr,
	input  xcpd_pkg::start_t            start,
	output logic                        busy,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [xcpd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);
	import xcpd_pkg::*;

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

	logic              active_q;
	logic              empty_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] idx_q;

	logic              pend_s1;
	logic [ADDR_W-1:0] pend_idx_s1;
	logic              pend_last_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	logic              out_valid_q;
	logic              out_last_q;
	logic              out_user_q;
	out_data_t         out_data_q;

	logic issue;
	logic is_last;

	assign busy = active_q | pend_s1;
	assign issue = active_q & ~pend_s1 & (~out_valid_q | m_tready);
	assign is_last = empty_q | ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			empty_q      <= 1'b0;
			cmd_q        <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			pend_s1      <= 1'b0;
			pend_idx_s1  <= '0;
			pend_last_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (start.go) begin
				active_q <= 1'b1;
				empty_q  <= (start.len == '0);
				cmd_q    <= start.cmd;
				len_q    <= start.len;
				idx_q    <= '0;
			end else if (issue) begin
				pend_idx_s1  <= idx_q;
				pend_last_s1 <= is_last;
				idx_q        <= idx_q + ADDR_W'(1);
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_user_q  <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
			out_last_q  <= pend_last_s1;
			out_user_q  <= ~empty_q;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_data_q.pad          <= '0;
			out_data_q.opcode       <= cmd_q;
			out_data_q.data_len     <= PLEN_W'(len_q);
			out_data_q.byte_index   <= BIDX_W'(pend_idx_s1);
			out_data_q.payload_byte <= empty_q ? '0 : rd_data_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

	`include "xor_checked_packet_deframer_core_macros.svh"

	`XCPD_ASSERT_SAME(a_no_write_while_emitting, wr.we, !busy)
	`XCPD_ASSERT_SAME(a_no_start_while_emitting, start.go, !busy)
	`XCPD_ASSERT_SAME(a_pending_read_has_slot, pend_s1, !out_valid_q)
	`XCPD_ASSERT_NEXT(a_pending_read_loads_output, pend_s1, out_valid_q)

endmodule

// ===== sv/xor_checked_packet_deframer_core.sv =====
// Channel   | Direction | Handshake           | Payload
// s_*       | in        | s_tvalid / s_tready | s_tdata[7:0] rx_byte
// m_*       | out       | m_tvalid / m_tready | tdata, tlast = last, tuser = has_payload
// cfg_*     | in        | cfg_valid/cfg_ready | cfg_data = sync_byte
//
// The payload bytes go into a 32-entry store. A packet that passes its check is
// read back from the store result by result, each by a store read and then an
// output load, a new read waiting until the previous one has loaded the output,
// while no input request is taken. An empty packet gives one result with no payload.
// Reset sets sync_byte to 0xAA and returns to the hunt; the store is not cleared.
// A stalled output holds its result; a read is issued only as the output slot frees.
module xor_checked_packet_deframer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] rx_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] opcode, [13:8] data_len, [18:14] byte_index,
	// [26:19] payload_byte, [31:27] zero
	output logic [xcpd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast,
	output logic                             m_tuser,  // [0] has_payload
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [7:0]                       cfg_data
);
	import xcpd_pkg::*;

	phase_t            phase_q;
	phase_t            phase_d;
	logic [7:0]        sync_q;
	logic [7:0]        xor_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [LEN_W-1:0]  exp_q;
	logic [LEN_W-1:0]  cnt_q;

	logic              busy;
	logic              acc;
	logic [BYTE_W-1:0] rx;
	wr_req_t           wr;
	start_t            start;

	assign rx        = s_tdata;
	assign s_tready  = ~busy;
	assign acc       = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= 8'hAA;
		end else if (cfg_valid) begin
			sync_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		wr.we      = 1'b0;
		wr.addr    = cnt_q[ADDR_W-1:0];
		wr.data    = rx;
		start.go   = 1'b0;
		start.cmd  = cmd_q;
		start.len  = exp_q;
		case (phase_q)
			PH_CMD: begin
				if (acc) begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (acc) begin
					if (rx > 8'(MAX_PAYLOAD)) begin
						phase_d = PH_HUNT;
					end else if (rx == '0) begin
						phase_d = PH_CHECK;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				wr.we = acc;
				if (acc && ((cnt_q + LEN_W'(1)) >= exp_q)) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (acc) begin
					start.go = ((xor_q ^ sync_q) == rx);
					phase_d  = PH_HUNT;
				end
			end
			default: begin
				if (acc && (rx == sync_q)) begin
					phase_d = PH_CMD;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q <= '0;
			cmd_q <= '0;
			exp_q <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			case (phase_q)
				PH_CMD: begin
					cmd_q <= rx;
					xor_q <= rx;
				end
				PH_LEN: begin
					if (rx <= 8'(MAX_PAYLOAD)) begin
						exp_q <= rx[LEN_W-1:0];
						cnt_q <= '0;
						xor_q <= xor_q ^ rx;
					end
				end
				PH_DATA: begin
					cnt_q <= cnt_q + LEN_W'(1);
					xor_q <= xor_q ^ rx;
				end
				default: begin
				end
			endcase
		end
	end

	xcpd_store_emit u_store_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.start    (start),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import xcpd_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS = 28;

	typedef struct packed {
		logic [CMD_W-1:0]  opcode;
		logic [PLEN_W-1:0] data_len;
		logic              has_payload;
		logic [BIDX_W-1:0] byte_index;
		logic [BYTE_W-1:0] payload_byte;
		logic              last;
	} frame_result_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_SINGLE
	} row_kind_t;

	typedef struct packed {
		logic [7:0]    rx;
		row_kind_t     kind;
		frame_result_t result;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [7:0]             cfg_data;

	frame_result_t expected_frames [$];
	int            mismatch_count;
	int            idle_cycles = 0;
	int            sender_calm;
	int            phase_items;
	int            burst_requests;

	phase_t     parse_state;
	logic [7:0] sync_value;
	logic [7:0] held_cmd;
	logic [5:0] want_len;
	logic [5:0] got_count;
	logic [7:0] payload_copy [MAX_PAYLOAD];

	stim_row_t directed_rows [0:23] = '{
		'{8'h00, ROW_SILENT, '0},
		'{8'hAA, ROW_PREDICT, '0},
		'{8'h5C, ROW_PREDICT, '0},
		'{8'h00, ROW_PREDICT, '0},
		'{8'hF6, ROW_SINGLE, '{8'h5C, 6'd0, 1'b0, 5'd0, 8'h00, 1'b1}},
		'{8'hAA, ROW_PREDICT, '0},
		'{8'hFF, ROW_PREDICT, '0},
		'{8'h01, ROW_PREDICT, '0},
		'{8'hFF, ROW_PREDICT, '0},
		'{8'hAB, ROW_SINGLE, '{8'hFF, 6'd1, 1'b1, 5'd0, 8'hFF, 1'b1}},
		'{8'hAA, ROW_PREDICT, '0},
		'{8'h00, ROW_PREDICT, '0},
		'{8'h21, ROW_SILENT, '0},
		'{8'hAA, ROW_PREDICT, '0},
		'{8'h00, ROW_PREDICT, '0},
		'{8'h00, ROW_PREDICT, '0},
		'{8'h00, ROW_SILENT, '0},
		'{8'hAA, ROW_PREDICT, '0},
		'{8'h03, ROW_PREDICT, '0},
		'{8'h03, ROW_PREDICT, '0},
		'{8'hAA, ROW_PREDICT, '0},
		'{8'h00, ROW_PREDICT, '0},
		'{8'hAA, ROW_PREDICT, '0},
		'{8'hAA, ROW_PREDICT, '0}
	};

	xor_checked_packet_deframer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return MAX_PAYLOAD;
		if (r < 3)
			return $urandom_range(7, MAX_PAYLOAD - 1);
		return $urandom_range(0, 6);
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] value, input bit record);
		logic [7:0]    check;
		frame_result_t r;
		case (parse_state)
			PH_CMD: begin
				held_cmd = value;
				parse_state = PH_LEN;
			end
			PH_LEN: begin
				if (value > MAX_PAYLOAD) begin
					parse_state = PH_HUNT;
				end else begin
					want_len = value[5:0];
					got_count = 6'd0;
					parse_state = (want_len == 6'd0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA: begin
				if (got_count < MAX_PAYLOAD)
					payload_copy[got_count[4:0]] = value;
				got_count = got_count + 6'd1;
				if (got_count >= want_len)
					parse_state = PH_CHECK;
			end
			PH_CHECK: begin
				check = sync_value ^ held_cmd ^ {2'b00, want_len};
				for (int i = 0; i < want_len && i < MAX_PAYLOAD; i++)
					check = check ^ payload_copy[i];
				if (check == value && record) begin
					if (want_len == 6'd0) begin
						r = '0;
						r.opcode = held_cmd;
						r.last = 1'b1;
						expected_frames.push_back(r);
					end else begin
						for (int i = 0; i < want_len && i < MAX_PAYLOAD; i++) begin
							r.opcode = held_cmd;
							r.data_len = want_len;
							r.has_payload = 1'b1;
							r.byte_index = i[4:0];
							r.payload_byte = payload_copy[i];
							r.last = (i + 1 == want_len);
							expected_frames.push_back(r);
						end
					end
				end
				parse_state = PH_HUNT;
			end
			default: begin
				parse_state = (value == sync_value) ? PH_CMD : PH_HUNT;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_byte(input logic [7:0] value, input bit record);
		int gap;
		if (sender_calm > 0) begin
			gap = 0;
			sender_calm--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 29) == 0)
				sender_calm = $urandom_range(20, 60);
		end
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		parse_rx_byte(value, record);
	endtask

	task automatic send_frame(input int len, input bit corrupt);
		logic [7:0] cmd;
		logic [7:0] check;
		logic [7:0] data;
		logic [7:0] mask;
		logic [7:0] frame [$];
		cmd = 8'($urandom);
		check = sync_value ^ cmd ^ len[7:0];
		frame.push_back(sync_value);
		frame.push_back(cmd);
		frame.push_back(len[7:0]);
		repeat (len) begin
			data = 8'($urandom);
			check = check ^ data;
			frame.push_back(data);
		end
		mask = 8'($urandom_range(1, 255));
		if (corrupt)
			check = check ^ mask;
		frame.push_back(check);
		foreach (frame[k])
			send_byte(frame[k], 1'b1);
		phase_items += frame.size();
	endtask

	task automatic send_oversize();
		logic [7:0] cmd;
		logic [7:0] len;
		cmd = 8'($urandom);
		len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
		send_byte(sync_value, 1'b1);
		send_byte(cmd, 1'b1);
		send_byte(len, 1'b1);
		phase_items += 3;
	endtask

	task automatic send_noise();
		logic [7:0] data;
		repeat ($urandom_range(1, 4)) begin
			data = 8'($urandom);
			send_byte(data, 1'b1);
			phase_items++;
		end
	endtask

	task automatic settle_hunt();
		while (parse_state != PH_HUNT)
			send_byte(sync_value ^ 8'h80, 1'b1);
	endtask

	task automatic random_phase(input int budget);
		int pick;
		phase_items = 0;
		while (phase_items < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				send_frame(pick_len(), 1'b0);
			else if (pick < 82)
				send_frame(pick_len(), 1'b1);
			else if (pick < 91)
				send_oversize();
			else
				send_noise();
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic change_sync(input logic [7:0] value);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sync_value = value;
	endtask

	initial begin : stimulus
		logic [7:0] odd_sync;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_data <= 8'h00;
		burst_requests <= 0;
		mismatch_count = 0;
		sender_calm = 0;
		parse_state = PH_HUNT;
		sync_value = 8'hAA;
		held_cmd = 8'h00;
		want_len = 6'd0;
		got_count = 6'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			send_byte(directed_rows[k].rx, directed_rows[k].kind == ROW_PREDICT);
			if (directed_rows[k].kind == ROW_SINGLE)
				expected_frames.push_back(directed_rows[k].result);
		end

		change_sync(8'h00);
		random_phase(PHASE_ITEMS);

		change_sync(8'hFF);
		settle_hunt();
		burst_requests <= burst_requests + 1;
		send_frame(MAX_PAYLOAD, 1'b0);
		random_phase(PHASE_ITEMS);

		odd_sync = 8'($urandom);
		if (odd_sync == 8'hAA)
			odd_sync = 8'h55;
		change_sync(odd_sync);
		random_phase(PHASE_ITEMS);

		change_sync(8'hAA);
		random_phase(PHASE_ITEMS);

		wait_drain();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : sink
		int gap_left;
		int calm_left;
		int burst_seen;
		gap_left = 0;
		calm_left = 0;
		burst_seen = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (burst_seen != burst_requests) begin
				burst_seen = burst_requests;
				gap_left = HOLD_CYCLES;
			end
			if (gap_left > 0) begin
				m_tready <= 1'b0;
				gap_left--;
			end else begin
				m_tready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					if ($urandom_range(0, 3) == 0)
						gap_left = pick_gap();
					if ($urandom_range(0, 49) == 0)
						calm_left = $urandom_range(20, 80);
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		frame_result_t want;
		out_data_t     beat;
		if (arst_n && m_tvalid && m_tready) begin
			beat = out_data_t'(m_tdata);
			if (expected_frames.size() == 0) begin
				report_mismatch("result with nothing expected", 32'(m_tdata), 32'd0);
			end else begin
				want = expected_frames.pop_front();
				if (beat.opcode !== want.opcode)
					report_mismatch("opcode", 32'(beat.opcode), 32'(want.opcode));
				if (beat.data_len !== want.data_len)
					report_mismatch("data_len", 32'(beat.data_len),
						32'(want.data_len));
				if (m_tuser !== want.has_payload)
					report_mismatch("has_payload", 32'(m_tuser), 32'(want.has_payload));
				if (beat.byte_index !== want.byte_index)
					report_mismatch("byte_index", 32'(beat.byte_index),
						32'(want.byte_index));
				if (beat.payload_byte !== want.payload_byte)
					report_mismatch("payload_byte", 32'(beat.payload_byte),
						32'(want.payload_byte));
				if (m_tlast !== want.last)
					report_mismatch("last", 32'(m_tlast), 32'(want.last));
				if (beat.pad !== '0)
					report_mismatch("tdata padding", 32'(beat.pad), 32'd0);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/xcpd_pkg.sv
sv/xcpd_store_emit.sv
sv/xor_checked_packet_deframer_core.sv
tb/sv/testbench.sv
